FILE: design/fcc_pkg.sv
// shared types and constants of the frustum cube cull unit
// no dependencies; used by every module of the block
package fcc_pkg;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  localparam int MAT_DIM     = 4;
  localparam int MAT_ELEMS   = MAT_DIM * MAT_DIM;
  localparam int PLANE_COUNT = 6;
  localparam int D_SHIFT     = 16;
  localparam int HALF_WIDTH  = 31;
  localparam int IN_WIDTH    = 32;

  // per-stage load enables, stage 1 is the input register
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } pipe_ld_t;

endpackage

FILE: design/fcc_matrix.sv
// clip matrix storage and plane component forming
// depends on fcc_pkg
module fcc_matrix #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  logic                                                    wr_en_i,
  input  logic [$clog2(fcc_pkg::MAT_ELEMS)-1:0]                   wr_idx_i,
  input  logic signed [VALUE_WIDTH-1:0]                           wr_val_i,
  output logic [fcc_pkg::PLANE_COUNT-1:0][fcc_pkg::MAT_DIM-1:0][VALUE_WIDTH:0] comp_o
);

  logic signed [VALUE_WIDTH-1:0] mat_q [fcc_pkg::MAT_ELEMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fcc_pkg::MAT_ELEMS; i++) begin
        mat_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      mat_q[wr_idx_i] <= wr_val_i;
    end
  end

  // plane p uses axis p/2, odd planes add and even planes subtract
  for (genvar p = 0; p < fcc_pkg::PLANE_COUNT; p++) begin : g_plane
    for (genvar r = 0; r < fcc_pkg::MAT_DIM; r++) begin : g_row
      localparam int BaseIdx  = r * fcc_pkg::MAT_DIM + fcc_pkg::MAT_DIM - 1;
      localparam int OtherIdx = r * fcc_pkg::MAT_DIM + (p >> 1);
      logic signed [VALUE_WIDTH:0] base_w;
      logic signed [VALUE_WIDTH:0] other_w;
      assign base_w  = (VALUE_WIDTH + 1)'(mat_q[BaseIdx]);
      assign other_w = (VALUE_WIDTH + 1)'(mat_q[OtherIdx]);
      if ((p & 1) == 1) begin : g_plus
        assign comp_o[p][r] = base_w + other_w;
      end else begin : g_minus
        assign comp_o[p][r] = base_w - other_w;
      end
    end
  end

endmodule

FILE: design/fcc_plane_eval.sv
// pipelined nearest-vertex test of one plane against a cube
// depends on fcc_pkg
module fcc_plane_eval #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                                clk_i,
  input  fcc_pkg::pipe_ld_t                                   ld_i,
  input  logic [fcc_pkg::MAT_DIM-1:0][VALUE_WIDTH:0]          comp_i,
  input  logic signed [VALUE_WIDTH-1:0]                       cx_i,
  input  logic signed [VALUE_WIDTH-1:0]                       cy_i,
  input  logic signed [VALUE_WIDTH-1:0]                       cz_i,
  input  logic [fcc_pkg::HALF_WIDTH-1:0]                      half_i,
  output logic                                                pass_o
);

  localparam int WP  = 2 * VALUE_WIDTH + 1;
  localparam int WS  = 2 * VALUE_WIDTH + 3;
  localparam int WA  = VALUE_WIDTH + 2;
  localparam int WAH = WA + fcc_pkg::HALF_WIDTH;
  localparam int WT  = ((WS > WAH + 1) ? WS : WAH + 1) + 2;

  // stage 1: plane components
  logic [fcc_pkg::MAT_DIM-1:0][VALUE_WIDTH:0] comp_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.ld1) begin
      comp_q <= comp_i;
    end
  end

  // stage 2: normal times centre, sum of normal magnitudes
  logic signed [WP-1:0]          prod_d [3];
  logic signed [WP-1:0]          prod_q [3];
  logic [VALUE_WIDTH:0]          mag_w  [3];
  logic [WA-1:0]                 abs_sum_d, abs_sum_q;
  logic signed [VALUE_WIDTH:0]   d2_q;

  always_comb begin
    prod_d[0] = $signed(comp_q[0]) * cx_i;
    prod_d[1] = $signed(comp_q[1]) * cy_i;
    prod_d[2] = $signed(comp_q[2]) * cz_i;
    for (int r = 0; r < 3; r++) begin
      mag_w[r] = comp_q[r][VALUE_WIDTH] ? (VALUE_WIDTH + 1)'(-$signed(comp_q[r]))
                                        : comp_q[r];
    end
    abs_sum_d = WA'(mag_w[0]) + WA'(mag_w[1]) + WA'(mag_w[2]);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld2) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[r] <= prod_d[r];
      end
      abs_sum_q <= abs_sum_d;
      d2_q      <= $signed(comp_q[fcc_pkg::MAT_DIM-1]);
    end
  end

  // stage 3: dot product sum, half size times magnitude sum
  logic signed [WS-1:0]         psum_q;
  logic [WAH-1:0]               ah_q;
  logic signed [VALUE_WIDTH:0]  d3_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.ld3) begin
      psum_q <= WS'(prod_q[0]) + WS'(prod_q[1]) + WS'(prod_q[2]);
      ah_q   <= WAH'(abs_sum_q) * WAH'(half_i);
      d3_q   <= d2_q;
    end
  end

  // final sum, sign test feeds the output register in the top level
  logic signed [WT-1:0] total_w;

  assign total_w = WT'(psum_q) + WT'($signed({1'b0, ah_q}))
                 + (WT'(d3_q) <<< fcc_pkg::D_SHIFT);
  assign pass_o  = !total_w[WT-1] && (total_w != '0);

endmodule

FILE: design/frustum_cube_cull_unit.sv
// frustum cube cull unit: top level with handshake control and output register
// depends on fcc_pkg, fcc_matrix and fcc_plane_eval
//
// usage:
//   one input channel (in_valid_i / in_stall_o) carries load and test words.
//   a load word (func_i = 0) writes elem_value_i into the clip matrix at
//   elem_index_i = row*4+col; the next word already sees the new value.
//   a load produces no output word.
//   a test word (func_i = 1) carries a cube centre and half size and yields
//   one output word on out_valid_o / out_stall_i with visible_o = 1 when no
//   frustum plane culls the cube.
//   a test word passes the input register, multiply stage, sum/multiply stage
//   and output register before its result shows on visible_o.
//   throughput: one word per cycle unless out_stall_i backs up the four-stage
//   pipeline, which sets this rate; each stage holds about one multiplier or one wide add.
//   stall: out_stall_i holds the output register; bubbles in earlier stages
//   still close up, so in_stall_o rises only when every stage holds a result.
//   reset: the clip matrix clears to zero (every cube culled) and the
//   pipeline empties.
module frustum_cube_cull_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [3:0]                          elem_index_i,
  input  logic signed [31:0]                  elem_value_i,
  input  logic signed [31:0]                  center_x_i,
  input  logic signed [31:0]                  center_y_i,
  input  logic signed [31:0]                  center_z_i,
  input  logic [fcc_pkg::HALF_WIDTH-1:0]      half_size_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                visible_o
);

  // stage valid bits, stage 4 is the output register
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  fcc_pkg::pipe_ld_t ld;

  // a stage may load when it is empty or its word moves on this cycle
  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign ld.ld1 = rdy1;
  assign ld.ld2 = rdy2;
  assign ld.ld3 = rdy3;
  assign ld.ld4 = rdy4;

  assign in_stall_o = !rdy1;

  logic accept_load, accept_test;
  assign accept_load = in_valid_i && rdy1 && (func_i == fcc_pkg::FUNC_LOAD);
  assign accept_test = in_valid_i && rdy1 && (func_i == fcc_pkg::FUNC_TEST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= accept_test;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // inputs wrap or sign-extend to the internal value width
  logic signed [VALUE_WIDTH-1:0] elem_w, cx_w, cy_w, cz_w;
  assign elem_w = VALUE_WIDTH'(elem_value_i);
  assign cx_w   = VALUE_WIDTH'(center_x_i);
  assign cy_w   = VALUE_WIDTH'(center_y_i);
  assign cz_w   = VALUE_WIDTH'(center_z_i);

  // clip matrix, plane components read as the test word enters
  logic [fcc_pkg::PLANE_COUNT-1:0][fcc_pkg::MAT_DIM-1:0][VALUE_WIDTH:0] comp_w;

  fcc_matrix #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_matrix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (accept_load),
    .wr_idx_i (elem_index_i),
    .wr_val_i (elem_w),
    .comp_o   (comp_w)
  );

  // cube registers: centre used in stage 2, half size in stage 3
  logic signed [VALUE_WIDTH-1:0]     cx_q, cy_q, cz_q;
  logic [fcc_pkg::HALF_WIDTH-1:0]    h1_q, h2_q;

  always_ff @(posedge clk_i) begin
    if (ld.ld1) begin
      cx_q <= cx_w;
      cy_q <= cy_w;
      cz_q <= cz_w;
      h1_q <= half_size_i;
    end
    if (ld.ld2) begin
      h2_q <= h1_q;
    end
  end

  // six planes evaluated side by side
  logic [fcc_pkg::PLANE_COUNT-1:0] pass_w;

  for (genvar p = 0; p < fcc_pkg::PLANE_COUNT; p++) begin : g_plane
    fcc_plane_eval #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_plane (
      .clk_i  (clk_i),
      .ld_i   (ld),
      .comp_i (comp_w[p]),
      .cx_i   (cx_q),
      .cy_i   (cy_q),
      .cz_i   (cz_q),
      .half_i (h2_q),
      .pass_o (pass_w[p])
    );
  end

  // output register, holds while the receiver stalls
  logic visible_q;

  always_ff @(posedge clk_i) begin
    if (ld.ld4) begin
      visible_q <= &pass_w;
    end
  end

  assign out_valid_o = v4_q;
  assign visible_o   = visible_q;

endmodule

FILE: tb/sv/tb_frustum_cube_cull_unit.sv
// self-checking testbench of frustum_cube_cull_unit: directed and random load/test words
// depends on fcc_pkg and the frustum_cube_cull_unit rtl; predicts visibility internally
`timescale 1ns / 1ps

module tb_frustum_cube_cull_unit;

  localparam int VALUE_W     = 32;
  localparam int CLK_HALF    = 5;
  localparam int TOTAL_WORDS = 750;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 8;     // a little over the four-stage latency
  localparam int HOLD_CYCLES = 120;   // long receiver hold-off to fill the pipe

  // ---------------------------------------------------------------------------
  // visibility tracker: shadow clip matrix, expected visible bits, checking
  // ---------------------------------------------------------------------------
  class visibility_tracker;
    longint clip_shadow[16];
    bit     expected_visible[$];
    int     errors;
    int     checked;

    function new();
      foreach (clip_shadow[i]) clip_shadow[i] = 0;
      errors  = 0;
      checked = 0;
    endfunction

    // sign-extend the 32-bit word, then wrap it to the matrix width
    function longint wrap_value(logic [31:0] raw);
      longint v;
      v = longint'(signed'(raw));
      if (VALUE_W < 64) v = (v <<< (64 - VALUE_W)) >>> (64 - VALUE_W);
      return v;
    endfunction

    // visible when every plane has n.c + (d << 16) + h*(|nx|+|ny|+|nz|) > 0
    function bit predict_visible(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                 logic [30:0] h);
      longint             ctr[3];
      longint             comp[4];
      longint             abs_sum;
      logic signed [127:0] acc;
      logic signed [127:0] lhs;
      logic signed [127:0] rhs;
      int                  axis;
      ctr[0] = wrap_value(cx);
      ctr[1] = wrap_value(cy);
      ctr[2] = wrap_value(cz);
      for (int p = 0; p < fcc_pkg::PLANE_COUNT; p++) begin
        axis = p >> 1;
        for (int r = 0; r < 4; r++) begin
          if (p & 1) comp[r] = clip_shadow[r*4 + 3] + clip_shadow[r*4 + axis];
          else comp[r] = clip_shadow[r*4 + 3] - clip_shadow[r*4 + axis];
        end
        acc     = 0;
        abs_sum = 0;
        for (int r = 0; r < 3; r++) begin
          lhs     = comp[r];
          rhs     = ctr[r];
          acc     = acc + lhs * rhs;
          abs_sum = abs_sum + ((comp[r] < 0) ? -comp[r] : comp[r]);
        end
        lhs = abs_sum;
        rhs = {97'd0, h};
        acc = acc + lhs * rhs;
        lhs = comp[3];
        acc = acc + (lhs <<< fcc_pkg::D_SHIFT);
        if (acc <= 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_word(logic func, logic [3:0] idx, logic [31:0] val,
                            logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [30:0] h);
      if (func == fcc_pkg::FUNC_LOAD) clip_shadow[idx] = wrap_value(val);
      else expected_visible.push_back(predict_visible(cx, cy, cz, h));
    endfunction

    function void check_visible(logic got);
      bit want;
      checked++;
      if (expected_visible.size() == 0) begin
        $error("visible: expected no word, actual %0b", got);
        errors++;
      end else begin
        want = expected_visible.pop_front();
        if (got !== want) begin
          $error("visible: expected %0b, actual %0b", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // dut signals and instance
  // ---------------------------------------------------------------------------
  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic                           func_i;
  logic [3:0]                     elem_index_i;
  logic signed [31:0]             elem_value_i;
  logic signed [31:0]             center_x_i;
  logic signed [31:0]             center_y_i;
  logic signed [31:0]             center_z_i;
  logic [fcc_pkg::HALF_WIDTH-1:0] half_size_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic                           visible_o;

  visibility_tracker tracker = new();

  int words_sent;
  int burst_left;
  int cycle_count;
  bit long_hold_done;

  frustum_cube_cull_unit #(
    .VALUE_WIDTH(VALUE_W)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .elem_index_i(elem_index_i),
    .elem_value_i(elem_value_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .center_z_i  (center_z_i),
    .half_size_i (half_size_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .visible_o   (visible_o)
  );

  // clock, 10 ns period
  initial clk_i = 1'b0;
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // run limit, counted in clock cycles
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // output monitor: a word moves when valid is high and stall is low at the edge;
  // values read here are the pre-edge ones, since everything else changes by nba
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_visible(visible_o);
  end

  // ---------------------------------------------------------------------------
  // random value helpers
  // ---------------------------------------------------------------------------

  // matrix element: full range, small Q16.16 values within +-2, or corner values
  function automatic logic [31:0] rand_elem(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($urandom_range(0, 262144)) - 32'd131072;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h0001_0000;
          2: return 32'hFFFF_0000;
          3: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
      3: return 32'h8000_0000 + 32'($urandom_range(0, 3));
      default: return 32'($urandom_range(0, 524288)) - 32'd262144;
    endcase
  endfunction

  function automatic logic [30:0] rand_half();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return 31'($urandom_range(0, 131072));
      default: return 31'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sender tasks
  // ---------------------------------------------------------------------------

  // offers one word and waits for the handshake; bursts end in a random gap
  task automatic send_word(logic func, logic [3:0] idx, logic [31:0] val,
                           logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [30:0] h);
    in_valid_i   <= 1'b1;
    func_i       <= func;
    elem_index_i <= idx;
    elem_value_i <= val;
    center_x_i   <= cx;
    center_y_i   <= cy;
    center_z_i   <= cz;
    half_size_i  <= h;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_word(func, idx, val, cx, cy, cz, h);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      // long bursts now and then give stretches with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // load word: the cube fields are don't-care, so they carry noise
  task automatic send_load(logic [3:0] idx, logic [31:0] val);
    send_word(fcc_pkg::FUNC_LOAD, idx, val, $urandom, $urandom, $urandom, 31'($urandom));
  endtask

  // test word: the element fields are don't-care, so they carry noise
  task automatic send_test(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [30:0] h);
    send_word(fcc_pkg::FUNC_TEST, 4'($urandom), $urandom, cx, cy, cz, h);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern of its own, plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int span;
    out_stall_i <= 1'b0;
    wait (rst_ni);
    forever begin
      // hold the output long enough that every stage fills and the input stalls
      if (!long_hold_done && tracker.checked >= 60) begin
        @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (int step = 0; step < span; step++) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;                          // free flow
          1: out_stall_i <= 1'($urandom_range(0, 1));      // coin flip
          2: out_stall_i <= (step % 3 == 0);               // periodic
          default: out_stall_i <= ($urandom_range(0, 9) < 7); // heavy back-pressure
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int choice;
    int kind;
    int start;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    func_i       <= fcc_pkg::FUNC_LOAD;
    elem_index_i <= '0;
    elem_value_i <= '0;
    center_x_i   <= '0;
    center_y_i   <= '0;
    center_z_i   <= '0;
    half_size_i  <= '0;
    words_sent   = 0;
    burst_left   = 4;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: matrix still all zero, so every cube is culled, even a huge one
    send_test(32'h0, 32'h0, 32'h0, '1);

    // identity matrix: planes x>-1, x<1 and the same for y and z
    send_load(4'd0,  32'h0001_0000);
    send_test(32'h0, 32'h0, 32'h0, '0);          // only one diagonal entry so far
    send_load(4'd5,  32'h0001_0000);
    send_load(4'd10, 32'h0001_0000);
    send_load(4'd15, 32'h0001_0000);
    send_test(32'h0, 32'h0, 32'h0, '0);          // centre point, zero size
    send_test(32'h0002_0000, 32'h0, 32'h0, '0);  // outside on x
    send_test(32'h0002_0000, 32'h0, 32'h0, 31'h0001_8000); // reaches back in
    send_test(32'h0001_0000, 32'h0, 32'h0, '0);  // exactly on the plane: culled
    send_test(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    send_test(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    send_test(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, '1);

    // corner element values, each seen by the next test word
    send_load(4'd15, 32'h7FFF_FFFF);
    send_test(32'h8000_0000, 32'h0, 32'h0, '0);
    send_load(4'd0,  32'h8000_0000);
    send_test(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, '1);
    send_load(4'd3,  32'h8000_0000);
    send_load(4'd12, 32'hFFFF_FFFF);
    send_test(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 31'h0000_0001);
    send_load(4'd7,  32'h7FFF_FFFF);
    send_test(32'h0, 32'h0, 32'h0, '1);

    // random: whole-matrix reloads followed by runs of tests, single loads, or short runs of tests
    while (words_sent < TOTAL_WORDS) begin
      choice = $urandom_range(0, 9);
      if (choice < 3) begin
        kind  = $urandom_range(0, 2);
        start = $urandom_range(0, 15);
        for (int i = 0; i < fcc_pkg::MAT_ELEMS; i++) begin
          send_load(4'((i + start) % fcc_pkg::MAT_ELEMS), rand_elem(kind));
        end
        repeat ($urandom_range(8, 30)) send_test(rand_coord(), rand_coord(), rand_coord(),
                                                 rand_half());
      end else if (choice < 5) begin
        send_load(4'($urandom_range(0, 15)), rand_elem($urandom_range(0, 2)));
      end else begin
        repeat ($urandom_range(1, 6)) send_test(rand_coord(), rand_coord(), rand_coord(),
                                                rand_half());
      end
    end

    // drop valid right after the last handshake so the final word is not offered again
    in_valid_i <= 1'b0;

    // drain every pending result, then let the pipeline settle
    while (tracker.expected_visible.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
